// ----- hw/rtl/rthc_pkg.sv -----
package rthc_pkg;

    localparam int MAX_TRI = 256;
    localparam int CNT_W   = 9;
    localparam int ADDR_W  = 10;
    localparam int DEPTH   = 3 * MAX_TRI;
    localparam int MW      = 52;    // multiplier operand width, signed
    localparam int CW      = 108;   // cross product and test width, signed
    localparam int RW      = 49;    // scaled ray vector width, signed
    localparam int CHW     = 16;    // multiplier digit width
    localparam int NCH     = 4;     // digits per multiply
    localparam int MBW     = CHW * NCH;
    localparam int NSTEP   = 28;    // multiplies per triangle
    localparam int NGRP    = 5;     // test groups per triangle

    typedef enum logic [1:0] {
        KIND_CLEAR = 2'd0,
        KIND_LOAD  = 2'd1,
        KIND_QUERY = 2'd2,
        KIND_NONE  = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_STORE,
        ST_RAY,
        ST_FETCH,
        ST_MUL,
        ST_TEST,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } mul_status_t;

    function automatic logic signed [MW-1:0] sx32(input logic [31:0] v);
        return {{(MW-32){v[31]}}, v};
    endfunction

    // sign test of num against the sign of a nonzero denominator
    function automatic logic sign_ok(input logic signed [CW-1:0] x, input logic den_neg);
        return den_neg ? (x[CW-1] || x == '0) : !x[CW-1];
    endfunction

endpackage

// ----- hw/rtl/rthc_ram.sv -----
module rthc_ram #(
    parameter int W = 64,
    parameter int D = 768
) (
    input  logic                 aclk,
    input  logic                 we,
    input  logic [$clog2(D)-1:0] waddr,
    input  logic [W-1:0]         wdata,
    input  logic [$clog2(D)-1:0] raddr,
    output logic [W-1:0]         rdata
);

    logic [W-1:0] mem [D];
    logic [W-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ----- hw/rtl/rthc_mul.sv -----
module rthc_mul (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          start,
    input  logic signed [rthc_pkg::MW-1:0] a,
    input  logic signed [rthc_pkg::MW-1:0] b,
    output logic signed [rthc_pkg::CW-1:0] prod,
    output rthc_pkg::mul_status_t          status
);
    import rthc_pkg::*;

    logic                busy_reg;
    logic                done_reg;
    logic [1:0]          cnt_reg;
    logic [MW-1:0]       ma_reg;
    logic [MBW-1:0]      mb_reg;
    logic [2*MW-1:0]     acc_reg;
    logic                neg_reg;
    logic [MW+CHW-1:0]   term;
    logic [2*MW-1:0]     term_sh;
    logic [MW-1:0]       mag_a;
    logic [MW-1:0]       mag_b;

    assign mag_a = a[MW-1] ? MW'(-a) : MW'(a);
    assign mag_b = b[MW-1] ? MW'(-b) : MW'(b);
    assign term  = ma_reg * mb_reg[CHW-1:0];

    always_comb begin
        case (cnt_reg)
            2'd0:    term_sh = (2*MW)'(term);
            2'd1:    term_sh = (2*MW)'({term, {CHW{1'b0}}});
            2'd2:    term_sh = (2*MW)'({term, {(2*CHW){1'b0}}});
            default: term_sh = (2*MW)'({term, {(3*CHW){1'b0}}});
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= busy_reg && (cnt_reg == 2'(NCH - 1));
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 2'd1;
                if (cnt_reg == 2'(NCH - 1)) begin
                    busy_reg <= 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            ma_reg  <= mag_a;
            mb_reg  <= MBW'(mag_b);
            acc_reg <= '0;
            neg_reg <= a[MW-1] ^ b[MW-1];
        end else if (busy_reg) begin
            acc_reg <= acc_reg + term_sh;
            mb_reg  <= mb_reg >> CHW;
        end
    end

    assign prod          = neg_reg ? -$signed(CW'(acc_reg)) : $signed(CW'(acc_reg));
    assign status.busy   = busy_reg;
    assign status.done   = done_reg;

`ifndef SYNTHESIS
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg)) else $error("product done without a multiply");
    a_no_overlap: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> !busy_reg) else $error("multiplier busy while done");
    a_four_digits: assert property (@(posedge aclk) disable iff (!aresetn)
        (start && !busy_reg) |=> ##4 done_reg) else $error("multiply took wrong cycle count");
`endif

endmodule

// ----- hw/rtl/ray_triangle_hit_counter.sv -----
// Counts the stored 2D triangles that a finite ray segment touches. A clear item empties
// the store, a load item writes its three vertices, and a load into a full store
// (256 triangles) is dropped. A query first scales the ray end (two multiplies), then per
// stored triangle fetches the vertices, runs 28 multiplies on the one shared 52-bit
// multiplier (16 bits of one operand a cycle) and 5 test groups. Ready returns after
// the last triangle, later only while the output register still holds an unaccepted result.
// A new item is taken while a finished result still waits.
module ray_triangle_hit_counter (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_kind,
    input  logic [31:0] s_ray_id,
    input  logic signed [31:0] s_vertex_a_x,
    input  logic signed [31:0] s_vertex_a_y,
    input  logic signed [31:0] s_vertex_b_x,
    input  logic signed [31:0] s_vertex_b_y,
    input  logic signed [31:0] s_vertex_c_x,
    input  logic signed [31:0] s_vertex_c_y,
    input  logic signed [31:0] s_origin_x,
    input  logic signed [31:0] s_origin_y,
    input  logic [63:0] s_direction_x_y,
    input  logic [31:0] s_ray_length,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_query_id,
    output logic [8:0]  m_touch_count
);
    import rthc_pkg::*;

    state_t state_reg, state_next;

    logic [CNT_W-1:0]  count_reg;
    logic [ADDR_W-1:0] wr_base_reg;
    logic [1:0]        k_reg;
    logic [63:0]       ld_reg [3];
    logic [ADDR_W-1:0] rd_addr_reg;
    logic [CNT_W-1:0]  tri_idx_reg;
    logic [63:0]       vtx_reg [3];
    logic [31:0]       id_reg;
    logic [31:0]       ox_reg, oy_reg, dx_reg, dy_reg, len_reg;
    logic [RW-1:0]     rx_reg, ry_reg;
    logic [4:0]        step_reg;
    logic              issue_reg;
    logic              issue_next;
    logic signed [CW-1:0] p1_reg;
    logic signed [CW-1:0] cr_reg [14];
    logic [2:0]        grp_reg;
    logic              hit_reg;
    logic [CNT_W-1:0]  hit_cnt_reg;
    logic              m_valid_reg;
    logic [31:0]       m_id_reg;
    logic [8:0]        m_cnt_reg;

    logic              accept;
    kind_t             kind;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [63:0]       ram_rdata;
    logic signed [MW-1:0] op_a, op_b;
    logic signed [CW-1:0] prod;
    mul_status_t       mst;
    logic signed [CW-1:0] rnd;

    logic signed [MW-1:0] ax, ay, bx, by, cx, cy, ox, oy, rx, ry, ex, ey;
    logic signed [MW-1:0] xx, xy, yx, yy;
    logic [3:0]        cj;
    logic signed [CW-1:0] den, n1, n2, diff1, diff2;
    logic              is_pt, pass;

    assign kind    = kind_t'(s_kind);
    assign s_ready = (state_reg == ST_IDLE);
    assign accept  = s_valid && s_ready;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (kind == KIND_LOAD && count_reg < CNT_W'(MAX_TRI)) begin
                        state_next = ST_STORE;
                    end else if (kind == KIND_QUERY) begin
                        state_next = ST_RAY;
                    end
                end
            end
            ST_STORE: if (k_reg == 2'd2) state_next = ST_IDLE;
            ST_RAY: begin
                if (mst.done && step_reg[0]) begin
                    state_next = (count_reg == '0) ? ST_DONE : ST_FETCH;
                end
            end
            ST_FETCH: if (k_reg == 2'd3) state_next = ST_MUL;
            ST_MUL: if (mst.done && step_reg == 5'(NSTEP - 1)) state_next = ST_TEST;
            ST_TEST: begin
                if (grp_reg == 3'(NGRP - 1)) begin
                    state_next = (tri_idx_reg + 1'b1 == count_reg) ? ST_DONE : ST_FETCH;
                end
            end
            ST_DONE: if (!m_valid_reg || m_ready) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // multiplier start pulse
    always_comb begin
        unique case (state_reg)
            ST_IDLE:  issue_next = accept && (kind == KIND_QUERY);
            ST_RAY:   issue_next = mst.done && !step_reg[0];
            ST_FETCH: issue_next = (k_reg == 2'd3);
            ST_MUL:   issue_next = mst.done && (step_reg != 5'(NSTEP - 1));
            default:  issue_next = 1'b0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // triangle store
    assign ram_we    = (state_reg == ST_STORE);
    assign ram_waddr = wr_base_reg + ADDR_W'(k_reg);

    rthc_ram #(.W(64), .D(DEPTH)) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ld_reg[k_reg]),
        .raddr (rd_addr_reg),
        .rdata (ram_rdata)
    );

    // operands
    assign ax = sx32(vtx_reg[0][63:32]);
    assign ay = sx32(vtx_reg[0][31:0]);
    assign bx = sx32(vtx_reg[1][63:32]);
    assign by = sx32(vtx_reg[1][31:0]);
    assign cx = sx32(vtx_reg[2][63:32]);
    assign cy = sx32(vtx_reg[2][31:0]);
    assign ox = sx32(ox_reg);
    assign oy = sx32(oy_reg);
    assign rx = {{(MW-RW){rx_reg[RW-1]}}, rx_reg};
    assign ry = {{(MW-RW){ry_reg[RW-1]}}, ry_reg};
    assign ex = ox + rx;
    assign ey = oy + ry;
    assign cj = step_reg[4:1];

    always_comb begin
        case (cj)
            4'd0:    begin xx = cx - ax; xy = cy - ay; yx = bx - ax; yy = by - ay; end
            4'd1:    begin xx = ox - ax; xy = oy - ay; yx = bx - ax; yy = by - ay; end
            4'd2:    begin xx = cx - ax; xy = cy - ay; yx = ox - ax; yy = oy - ay; end
            4'd3:    begin xx = ex - ax; xy = ey - ay; yx = bx - ax; yy = by - ay; end
            4'd4:    begin xx = cx - ax; xy = cy - ay; yx = ex - ax; yy = ey - ay; end
            4'd5:    begin xx = rx;      xy = ry;      yx = bx - ax; yy = by - ay; end
            4'd6:    begin xx = ax - ox; xy = ay - oy; yx = bx - ax; yy = by - ay; end
            4'd7:    begin xx = ax - ox; xy = ay - oy; yx = rx;      yy = ry;      end
            4'd8:    begin xx = rx;      xy = ry;      yx = cx - bx; yy = cy - by; end
            4'd9:    begin xx = bx - ox; xy = by - oy; yx = cx - bx; yy = cy - by; end
            4'd10:   begin xx = bx - ox; xy = by - oy; yx = rx;      yy = ry;      end
            4'd11:   begin xx = rx;      xy = ry;      yx = ax - cx; yy = ay - cy; end
            4'd12:   begin xx = cx - ox; xy = cy - oy; yx = ax - cx; yy = ay - cy; end
            default: begin xx = cx - ox; xy = cy - oy; yx = rx;      yy = ry;      end
        endcase
        if (state_reg == ST_RAY) begin
            op_a = step_reg[0] ? sx32(dy_reg) : sx32(dx_reg);
            op_b = $signed(MW'(len_reg));
        end else begin
            op_a = step_reg[0] ? xy : xx;
            op_b = step_reg[0] ? yx : yy;
        end
    end

    rthc_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (issue_reg),
        .a       (op_a),
        .b       (op_b),
        .prod    (prod),
        .status  (mst)
    );

    // round to nearest, ties up
    assign rnd = prod + CW'(32768);

    // tests
    always_comb begin
        case (grp_reg)
            3'd0:    begin den = cr_reg[0];  n1 = cr_reg[1];  n2 = cr_reg[2];  end
            3'd1:    begin den = cr_reg[0];  n1 = cr_reg[3];  n2 = cr_reg[4];  end
            3'd2:    begin den = cr_reg[5];  n1 = cr_reg[6];  n2 = cr_reg[7];  end
            3'd3:    begin den = cr_reg[8];  n1 = cr_reg[9];  n2 = cr_reg[10]; end
            default: begin den = cr_reg[11]; n1 = cr_reg[12]; n2 = cr_reg[13]; end
        endcase
        is_pt = (grp_reg < 3'd2);
        diff1 = is_pt ? (den - n1 - n2) : (den - n1);
        diff2 = den - n2;
        pass  = (den != '0) && sign_ok(n1, den[CW-1]) && sign_ok(n2, den[CW-1]) &&
                sign_ok(diff1, den[CW-1]) && (is_pt || sign_ok(diff2, den[CW-1]));
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            wr_base_reg <= '0;
            k_reg       <= '0;
            rd_addr_reg <= '0;
            tri_idx_reg <= '0;
            step_reg    <= '0;
            issue_reg   <= 1'b0;
            grp_reg     <= '0;
            hit_reg     <= 1'b0;
            hit_cnt_reg <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            issue_reg <= issue_next;
            if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    k_reg <= '0;
                    if (accept) begin
                        if (kind == KIND_CLEAR) begin
                            count_reg   <= '0;
                            wr_base_reg <= '0;
                        end else if (kind == KIND_QUERY) begin
                            step_reg    <= '0;
                            rd_addr_reg <= '0;
                            tri_idx_reg <= '0;
                            hit_cnt_reg <= '0;
                        end
                    end
                end
                ST_STORE: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg == 2'd2) begin
                        count_reg   <= count_reg + 1'b1;
                        wr_base_reg <= wr_base_reg + ADDR_W'(3);
                    end
                end
                ST_RAY: begin
                    if (mst.done) begin
                        step_reg <= step_reg[0] ? 5'd0 : 5'd1;
                    end
                    k_reg <= '0;
                end
                ST_FETCH: begin
                    k_reg <= k_reg + 2'd1;
                    if (k_reg != 2'd3) begin
                        rd_addr_reg <= rd_addr_reg + 1'b1;
                    end else begin
                        step_reg <= '0;
                    end
                end
                ST_MUL: begin
                    grp_reg <= '0;
                    hit_reg <= 1'b0;
                    if (mst.done && step_reg != 5'(NSTEP - 1)) begin
                        step_reg <= step_reg + 1'b1;
                    end
                end
                ST_TEST: begin
                    grp_reg <= grp_reg + 1'b1;
                    hit_reg <= hit_reg | pass;
                    if (grp_reg == 3'(NGRP - 1)) begin
                        tri_idx_reg <= tri_idx_reg + 1'b1;
                        hit_cnt_reg <= hit_cnt_reg + CNT_W'(hit_reg | pass);
                        k_reg       <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (accept && kind == KIND_LOAD) begin
            ld_reg[0] <= {s_vertex_a_x, s_vertex_a_y};
            ld_reg[1] <= {s_vertex_b_x, s_vertex_b_y};
            ld_reg[2] <= {s_vertex_c_x, s_vertex_c_y};
        end
        if (accept && kind == KIND_QUERY) begin
            id_reg  <= s_ray_id;
            ox_reg  <= s_origin_x;
            oy_reg  <= s_origin_y;
            dx_reg  <= s_direction_x_y[63:32];
            dy_reg  <= s_direction_x_y[31:0];
            len_reg <= s_ray_length;
        end
        if (state_reg == ST_RAY && mst.done) begin
            if (step_reg[0]) begin
                ry_reg <= rnd[RW+15:16];
            end else begin
                rx_reg <= rnd[RW+15:16];
            end
        end
        if (state_reg == ST_FETCH && k_reg != 2'd0) begin
            vtx_reg[k_reg - 2'd1] <= ram_rdata;
        end
        if (state_reg == ST_MUL && mst.done) begin
            if (step_reg[0]) begin
                cr_reg[cj] <= p1_reg - prod;
            end else begin
                p1_reg <= prod;
            end
        end
        if (state_reg == ST_DONE && (!m_valid_reg || m_ready)) begin
            m_id_reg  <= id_reg;
            m_cnt_reg <= hit_cnt_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_query_id    = m_id_reg;
    assign m_touch_count = m_cnt_reg;

`ifndef SYNTHESIS
    a_hits_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        hit_cnt_reg <= tri_idx_reg) else $error("more hits than triangles walked");
    a_count_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(MAX_TRI)) else $error("store count beyond capacity");
    a_mul_in_use: assert property (@(posedge aclk) disable iff (!aresetn)
        mst.done |-> (state_reg == ST_RAY || state_reg == ST_MUL))
        else $error("product arrived outside a multiply phase");
    a_walk_in_store: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_FETCH) |-> (tri_idx_reg < count_reg))
        else $error("fetch beyond stored triangles");
    a_issue_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        issue_reg |-> !mst.busy) else $error("multiply issued while busy");
`endif

endmodule
